// ----- hw/rtl/stit_pkg.sv -----
// stit_pkg: shared types and constants for the sorted timestamp insert table.
// Used by stit_front, stit_cmd_fifo, stit_back and the top level.
// No dependencies.
package stit_pkg;

    // Operation codes on the opcode port
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // Command queue between front and back
    localparam int CMDQ_AW    = 1;
    localparam int CMDQ_DEPTH = 2 ** CMDQ_AW;

    // Date-time key, year most significant, so the packed value orders like the key
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
    } key_t;

    localparam int KEY_W = $bits(key_t);

    // One stored table entry
    typedef struct packed {
        key_t        key;
        logic [15:0] tag;
    } entry_t;

    // Decoded command handed from front to back
    typedef struct packed {
        logic        is_read;
        key_t        key;
        logic [15:0] tag;
        logic [5:0]  rpos;
    } cmd_t;

endpackage

// ----- hw/rtl/stit_front.sv -----
// stit_front: input stage; takes a transfer, decodes it into a command and
// pushes it into the command queue. Depends on stit_pkg.
module stit_front
    import stit_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [13:0] key_year,
    input  logic [3:0]  key_month,
    input  logic [4:0]  key_day,
    input  logic [4:0]  key_hour,
    input  logic [5:0]  key_minute,
    input  logic [15:0] entry_tag,
    input  logic [5:0]  read_position,
    output logic        push,
    output cmd_t        push_cmd,
    input  logic        q_full
);

    logic vld_reg;
    logic vld_next;
    cmd_t cmd_reg;
    logic take;

    assign busy     = vld_reg && q_full;
    assign take     = start && !busy;
    assign push     = vld_reg && !q_full;
    assign push_cmd = cmd_reg;

    assign vld_next = take || (vld_reg && !push);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg.is_read    <= (opcode == OP_READ);
            cmd_reg.key.year   <= key_year;
            cmd_reg.key.month  <= key_month;
            cmd_reg.key.day    <= key_day;
            cmd_reg.key.hour   <= key_hour;
            cmd_reg.key.minute <= key_minute;
            cmd_reg.tag        <= entry_tag;
            cmd_reg.rpos       <= read_position;
        end
    end

endmodule

// ----- hw/rtl/stit_cmd_fifo.sv -----
// stit_cmd_fifo: short command queue between front and back.
// Depends on stit_pkg.
module stit_cmd_fifo
    import stit_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t head,
    output logic empty
);

    cmd_t                 slot_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]   wr_ptr_reg;
    logic [CMDQ_AW-1:0]   wr_ptr_next;
    logic [CMDQ_AW-1:0]   rd_ptr_reg;
    logic [CMDQ_AW-1:0]   rd_ptr_next;
    logic [CMDQ_AW:0]     fill_reg;
    logic [CMDQ_AW:0]     fill_next;

    assign full  = (fill_reg == (CMDQ_AW+1)'(CMDQ_DEPTH));
    assign empty = (fill_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + CMDQ_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + CMDQ_AW'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + (CMDQ_AW+1)'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - (CMDQ_AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- hw/rtl/stit_back.sv -----
// stit_back: executes commands against the entry memory and drives results.
// Insert scans from the tail down, shifting entries up by one. Depends on stit_pkg.
module stit_back
    import stit_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        head,
    input  logic        q_empty,
    output logic        pop,
    output logic        done,
    output logic [5:0]  position,
    output logic        table_full,
    output logic        bad_position,
    output logic [6:0]  entry_count,
    output logic [13:0] out_year,
    output logic [3:0]  out_month,
    output logic [4:0]  out_day,
    output logic [4:0]  out_hour,
    output logic [5:0]  out_minute,
    output logic [15:0] out_tag
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 6) ? CW : 6;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_PLACE  = 4'b0100,
        ST_RDWAIT = 4'b1000
    } back_state_t;

    back_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    cmd_t          cmd_reg, cmd_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic          rd_more_reg, rd_more_next;
    logic          cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0] cmp_idx_reg, cmp_idx_next;

    logic          done_reg, done_next;
    logic [5:0]    pos_reg, pos_next;
    logic          full_reg, full_next;
    logic          bad_reg, bad_next;
    logic [6:0]    cnt_out_reg, cnt_out_next;
    entry_t        data_reg, data_next;

    entry_t        mem [CAPACITY];
    entry_t        rdata_reg;
    logic          we;
    logic [AW-1:0] waddr;
    entry_t        wdata;
    logic [AW-1:0] raddr;

    logic [KEY_W-1:0] stored_key;
    logic [KEY_W-1:0] new_key;
    entry_t           new_entry;
    logic [CMPW-1:0]  rp_ext;
    logic [CMPW-1:0]  count_ext;
    logic [CW-1:0]    count_inc;

    assign stored_key    = rdata_reg.key;
    assign new_key       = cmd_reg.key;
    assign new_entry.key = cmd_reg.key;
    assign new_entry.tag = cmd_reg.tag;
    assign rp_ext        = CMPW'(head.rpos);
    assign count_ext     = CMPW'(count_reg);
    assign count_inc     = count_reg + CW'(1);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        cmd_next     = cmd_reg;
        rd_idx_next  = rd_idx_reg;
        rd_more_next = rd_more_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        pop          = 1'b0;
        we           = 1'b0;
        waddr        = '0;
        wdata        = new_entry;
        raddr        = rd_idx_reg;
        done_next    = 1'b0;
        pos_next     = pos_reg;
        full_next    = full_reg;
        bad_next     = bad_reg;
        cnt_out_next = cnt_out_reg;
        data_next    = data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                raddr = AW'(head.rpos);
                if (!q_empty)
                begin
                    pop      = 1'b1;
                    cmd_next = head;
                    if (!head.is_read)
                    begin
                        if (count_reg >= CW'(CAPACITY))
                        begin
                            // table full: drop
                            done_next    = 1'b1;
                            pos_next     = '0;
                            full_next    = 1'b1;
                            bad_next     = 1'b0;
                            cnt_out_next = 7'(count_reg);
                            data_next    = '0;
                        end
                        else if (count_reg == '0)
                        begin
                            we           = 1'b1;
                            waddr        = '0;
                            wdata.key    = head.key;
                            wdata.tag    = head.tag;
                            count_next   = count_inc;
                            done_next    = 1'b1;
                            pos_next     = '0;
                            full_next    = 1'b0;
                            bad_next     = 1'b0;
                            cnt_out_next = 7'(count_inc);
                            data_next    = '0;
                        end
                        else
                        begin
                            rd_idx_next  = AW'(count_reg - CW'(1));
                            rd_more_next = 1'b1;
                            state_next   = ST_SCAN;
                        end
                    end
                    else if (rp_ext >= count_ext)
                    begin
                        done_next    = 1'b1;
                        pos_next     = head.rpos;
                        full_next    = 1'b0;
                        bad_next     = 1'b1;
                        cnt_out_next = 7'(count_reg);
                        data_next    = '0;
                    end
                    else
                    begin
                        state_next = ST_RDWAIT;
                    end
                end
            end

            ST_RDWAIT:
            begin
                done_next    = 1'b1;
                pos_next     = cmd_reg.rpos;
                full_next    = 1'b0;
                bad_next     = 1'b0;
                cnt_out_next = 7'(count_reg);
                data_next    = rdata_reg;
                state_next   = ST_IDLE;
            end

            ST_SCAN:
            begin
                // read one entry ahead of the compare
                if (rd_more_reg)
                begin
                    rd_idx_next  = rd_idx_reg - AW'(1);
                    rd_more_next = (rd_idx_reg != '0);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = rd_idx_reg;
                end
                if (cmp_vld_reg)
                begin
                    we    = 1'b1;
                    waddr = cmp_idx_reg + AW'(1);
                    if (stored_key >= new_key)
                    begin
                        wdata = rdata_reg;
                        if (cmp_idx_reg == '0)
                        begin
                            state_next = ST_PLACE;
                        end
                    end
                    else
                    begin
                        count_next   = count_inc;
                        done_next    = 1'b1;
                        pos_next     = 6'(waddr);
                        full_next    = 1'b0;
                        bad_next     = 1'b0;
                        cnt_out_next = 7'(count_inc);
                        data_next    = '0;
                        state_next   = ST_IDLE;
                    end
                end
            end

            ST_PLACE:
            begin
                we           = 1'b1;
                waddr        = '0;
                count_next   = count_inc;
                done_next    = 1'b1;
                pos_next     = '0;
                full_next    = 1'b0;
                bad_next     = 1'b0;
                cnt_out_next = 7'(count_inc);
                data_next    = '0;
                state_next   = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            rd_more_reg <= 1'b0;
            cmp_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_more_reg <= rd_more_next;
            cmp_vld_reg <= cmp_vld_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        rd_idx_reg  <= rd_idx_next;
        cmp_idx_reg <= cmp_idx_next;
        pos_reg     <= pos_next;
        full_reg    <= full_next;
        bad_reg     <= bad_next;
        cnt_out_reg <= cnt_out_next;
        data_reg    <= data_next;
    end

    // entry memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign done         = done_reg;
    assign position     = pos_reg;
    assign table_full   = full_reg;
    assign bad_position = bad_reg;
    assign entry_count  = cnt_out_reg;
    assign out_year     = data_reg.key.year;
    assign out_month    = data_reg.key.month;
    assign out_day      = data_reg.key.day;
    assign out_hour     = data_reg.key.hour;
    assign out_minute   = data_reg.key.minute;
    assign out_tag      = data_reg.tag;

endmodule

// ----- hw/rtl/sorted_timestamp_insert_table.sv -----
// Sorted timestamp insert table, top level.
// Channels: command in (start/busy) with opcode, key fields, entry_tag and
//   read_position; a transfer happens on a clock edge with start high and busy low.
// Results: one per command, shown for exactly one cycle while done is high;
//   the receiver cannot stall, so results never back up into the block.
// Insert (opcode 0) places the entry ahead of the first held entry whose key
//   is not earlier (year, month, day, hour, minute order), else at the end;
//   a full table drops it and sets table_full. Read (opcode 1) returns the
//   entry at read_position, or bad_position when it is not below the count.
// Insert scans from the tail toward the landing position over the one-read
//   one-write entry memory, moving one entry per cycle, so a head insert
//   is the slowest command and sets the rate. A dropped insert, an
//   out-of-range read or an insert into an empty table needs no scan, and a
//   good read waits only for the registered memory read.
// A two-deep command queue lets the front keep taking transfers while the
//   back scans; busy rises only when front stage and queue are both full.
// Reset (rst_n low, asynchronous) empties the table and queue; memory contents
//   are not cleared, since only written positions are ever read.
module sorted_timestamp_insert_table
    import stit_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [13:0] key_year,
    input  logic [3:0]  key_month,
    input  logic [4:0]  key_day,
    input  logic [4:0]  key_hour,
    input  logic [5:0]  key_minute,
    input  logic [15:0] entry_tag,
    input  logic [5:0]  read_position,
    output logic        done,
    output logic [5:0]  position,
    output logic        table_full,
    output logic        bad_position,
    output logic [6:0]  entry_count,
    output logic [13:0] out_year,
    output logic [3:0]  out_month,
    output logic [4:0]  out_day,
    output logic [4:0]  out_hour,
    output logic [5:0]  out_minute,
    output logic [15:0] out_tag
);

    // front -> queue
    logic push;
    cmd_t push_cmd;
    logic q_full;

    // queue -> back
    logic pop;
    cmd_t head;
    logic q_empty;

    stit_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .key_year      (key_year),
        .key_month     (key_month),
        .key_day       (key_day),
        .key_hour      (key_hour),
        .key_minute    (key_minute),
        .entry_tag     (entry_tag),
        .read_position (read_position),
        .push          (push),
        .push_cmd      (push_cmd),
        .q_full        (q_full)
    );

    stit_cmd_fifo u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty)
    );

    // back end: owns the entry memory and the held count
    stit_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_empty      (q_empty),
        .pop          (pop),
        .done         (done),
        .position     (position),
        .table_full   (table_full),
        .bad_position (bad_position),
        .entry_count  (entry_count),
        .out_year     (out_year),
        .out_month    (out_month),
        .out_day      (out_day),
        .out_hour     (out_hour),
        .out_minute   (out_minute),
        .out_tag      (out_tag)
    );

endmodule
